// ===== rtl/core/cxwd_pkg.sv =====
// Package for the cumulative-XOR window decoder: sizes, register indexes,
// window phase type and the KOI8-R character class functions.
// Depends on nothing; imported by cumsum_xor_window_decoder_unit.
`default_nettype none

package cxwd_pkg;

    localparam int WINDOW_BYTES = 64;
    localparam int SCREEN_BYTES = 8;
    localparam int BYTE_W       = 8;
    localparam int KEY_W        = 64;
    localparam int MINRUN_W     = 4;
    localparam int LEN_W        = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int POS_W        = $clog2(WINDOW_BYTES + 1);
    localparam int SCR_IDX_W    = $clog2(SCREEN_BYTES);
    localparam int KEY_IDX_W    = $clog2(KEY_W / BYTE_W);

    // A full screen closes the window at once when the window is no longer than the screen.
    localparam logic FULL_SCREEN_ENDS = (SCREEN_BYTES >= WINDOW_BYTES);

    localparam logic [BYTE_W-1:0] CYR_LOW   = 8'hC0;
    localparam logic [BYTE_W-1:0] CYR_EXCL  = 8'hFF;
    localparam logic [BYTE_W-1:0] PRINT_LOW = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_END = 8'h7F;

    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN    = 2'd1;

    typedef enum logic [2:0] {
        PH_DONE   = 3'b001,
        PH_SCREEN = 3'b010,
        PH_EXTEND = 3'b100
    } phase_t;

    function automatic logic is_cyrillic(input logic [BYTE_W-1:0] v);
        return (v >= CYR_LOW) && (v != CYR_EXCL);
    endfunction

    function automatic logic is_printable(input logic [BYTE_W-1:0] v);
        return (v >= PRINT_LOW) && (v < PRINT_END);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cumsum_xor_window_decoder_unit.sv =====
// Cumulative-XOR window decoder with KOI8-R screening of the first bytes.
// Depends on cxwd_pkg for sizes, register indexes, phase type and class tests.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  cipher    | cipher_valid / cipher_stall| cipher_byte, window_start
//  result    | result_valid / result_stall| plain_byte, byte_valid, window_end, text_length
//  cfg       | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Each accepted byte is held in an input register and decoded combinationally into the
// result register, so one byte per cycle is sustained while no result stalls and no screen
// drains. When the screen is accepted its buffered bytes (up to eight) leave one per cycle
// from the screen buffer while no result stalls, and the input register holds meanwhile.
// While a stalled result waits, the input register holds its byte and further input stalls.
// Reset clears the control state; the screen buffer is not cleared.
`default_nettype none

module cumsum_xor_window_decoder_unit
    import cxwd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cipher_valid,
    output      logic                  cipher_stall,
    input  wire logic [BYTE_W-1:0]     cipher_byte,
    input  wire logic                  window_start,
    output      logic                  result_valid,
    input  wire logic                  result_stall,
    output      logic [BYTE_W-1:0]     plain_byte,
    output      logic                  byte_valid,
    output      logic                  window_end,
    output      logic [LEN_W-1:0]      text_length,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [KEY_W-1:0]      cfg_data
);

    logic [KEY_W-1:0]     cipher_key_reg;
    logic [MINRUN_W-1:0]  min_run_reg;

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_start_reg;

    phase_t               phase_reg, phase_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [BYTE_W-1:0]    prev_reg, prev_next;
    logic [BYTE_W-1:0]    screen_buf_reg [SCREEN_BYTES];

    logic                 drain_active_reg, drain_active_next;
    logic [SCR_IDX_W-1:0] drain_idx_reg, drain_idx_next;
    logic [SCR_IDX_W-1:0] drain_last_reg, drain_last_next;
    logic                 drain_end_reg, drain_end_next;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 out_bv_reg, out_bv_next;
    logic                 out_end_reg, out_end_next;
    logic [LEN_W-1:0]     out_len_reg, out_len_next;

    logic                 can_load;
    logic                 advance;
    phase_t               phase_eff;
    logic [POS_W-1:0]     pos_eff;
    logic [POS_W-1:0]     pos_inc;
    logic [BYTE_W-1:0]    prev_eff;
    logic [BYTE_W-1:0]    key_byte;
    logic [BYTE_W-1:0]    counter;
    logic [BYTE_W-1:0]    v;
    logic                 buf_we;
    logic                 direct_res;
    logic [BYTE_W-1:0]    direct_byte;
    logic                 direct_bv;
    logic                 direct_end;
    logic [LEN_W-1:0]     direct_len;

    assign cfg_ready    = 1'b1;
    assign can_load     = !out_valid_reg || !result_stall;
    assign advance      = in_valid_reg && !drain_active_reg && can_load;
    assign cipher_stall = in_valid_reg && !advance;

    assign result_valid = out_valid_reg;
    assign plain_byte   = out_byte_reg;
    assign byte_valid   = out_bv_reg;
    assign window_end   = out_end_reg;
    assign text_length  = out_len_reg;

    // A window start resets position and running plaintext before this byte is decoded.
    assign phase_eff = in_start_reg ? PH_SCREEN : phase_reg;
    assign pos_eff   = in_start_reg ? '0 : position_reg;
    assign prev_eff  = in_start_reg ? '0 : prev_reg;
    assign pos_inc   = pos_eff + 1'b1;
    assign key_byte  = cipher_key_reg[BYTE_W * pos_eff[KEY_IDX_W-1:0] +: BYTE_W];
    assign counter   = BYTE_W'(pos_eff >> KEY_IDX_W);
    assign v         = (in_byte_reg ^ (key_byte + counter)) + prev_eff;

    always_comb
    begin
        phase_next        = phase_reg;
        position_next     = position_reg;
        prev_next         = prev_reg;
        buf_we            = 1'b0;
        drain_active_next = drain_active_reg;
        drain_idx_next    = drain_idx_reg;
        drain_last_next   = drain_last_reg;
        drain_end_next    = drain_end_reg;
        direct_res        = 1'b0;
        direct_byte       = '0;
        direct_bv         = 1'b0;
        direct_end        = 1'b0;
        direct_len        = '0;

        if (drain_active_reg && can_load)
        begin
            drain_idx_next = drain_idx_reg + 1'b1;
            if (drain_idx_reg == drain_last_reg)
            begin
                drain_active_next = 1'b0;
            end
        end

        if (advance)
        begin
            phase_next    = phase_eff;
            position_next = pos_eff;
            prev_next     = prev_eff;
            case (phase_eff)
                PH_SCREEN:
                begin
                    if (v == '0)
                    begin
                        phase_next = PH_DONE;
                        if (pos_eff < POS_W'(min_run_reg))
                        begin
                            direct_res = 1'b0;
                        end
                        else if (pos_eff == '0)
                        begin
                            direct_res = 1'b1;
                            direct_end = 1'b1;
                        end
                        else
                        begin
                            drain_active_next = 1'b1;
                            drain_idx_next    = '0;
                            drain_last_next   = SCR_IDX_W'(pos_eff - 1'b1);
                            drain_end_next    = 1'b1;
                        end
                    end
                    else if (!is_cyrillic(v))
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        buf_we        = 1'b1;
                        prev_next     = v;
                        position_next = pos_inc;
                        if (pos_inc < POS_W'(SCREEN_BYTES))
                        begin
                            phase_next = PH_SCREEN;
                        end
                        else if (pos_inc < POS_W'(min_run_reg))
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            drain_active_next = 1'b1;
                            drain_idx_next    = '0;
                            drain_last_next   = SCR_IDX_W'(SCREEN_BYTES - 1);
                            drain_end_next    = FULL_SCREEN_ENDS;
                            phase_next        = FULL_SCREEN_ENDS ? PH_DONE : PH_EXTEND;
                        end
                    end
                end
                PH_EXTEND:
                begin
                    direct_res = 1'b1;
                    if ((v == '0) || !(is_cyrillic(v) || is_printable(v)))
                    begin
                        direct_end = 1'b1;
                        direct_len = LEN_W'(pos_eff);
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        prev_next     = v;
                        position_next = pos_inc;
                        direct_byte   = v;
                        direct_bv     = 1'b1;
                        direct_len    = LEN_W'(pos_inc);
                        if (pos_inc >= POS_W'(WINDOW_BYTES))
                        begin
                            direct_end = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_end_next   = out_end_reg;
        out_len_next   = out_len_reg;
        if (can_load)
        begin
            out_valid_next = drain_active_reg || (advance && direct_res);
            if (drain_active_reg)
            begin
                out_byte_next = screen_buf_reg[drain_idx_reg];
                out_bv_next   = 1'b1;
                out_end_next  = drain_end_reg && (drain_idx_reg == drain_last_reg);
                out_len_next  = LEN_W'(drain_idx_reg) + 1'b1;
            end
            else
            begin
                out_byte_next = direct_byte;
                out_bv_next   = direct_bv;
                out_end_next  = direct_end;
                out_len_next  = direct_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg   <= '0;
            min_run_reg      <= MINRUN_W'(4);
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_DONE;
            position_reg     <= '0;
            prev_reg         <= '0;
            drain_active_reg <= 1'b0;
            drain_idx_reg    <= '0;
            drain_last_reg   <= '0;
            drain_end_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CIPHER_KEY: cipher_key_reg <= cfg_data;
                    CFG_MIN_RUN:    min_run_reg    <= cfg_data[MINRUN_W-1:0];
                    default:        ;
                endcase
            end
            if (cipher_valid && !cipher_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            phase_reg        <= phase_next;
            position_reg     <= position_next;
            prev_reg         <= prev_next;
            drain_active_reg <= drain_active_next;
            drain_idx_reg    <= drain_idx_next;
            drain_last_reg   <= drain_last_next;
            drain_end_reg    <= drain_end_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cipher_valid && !cipher_stall)
        begin
            in_byte_reg  <= cipher_byte;
            in_start_reg <= window_start;
        end
        if (buf_we)
        begin
            screen_buf_reg[pos_eff[SCR_IDX_W-1:0]] <= v;
        end
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        out_end_reg  <= out_end_next;
        out_len_reg  <= out_len_next;
    end

`ifndef SYNTHESIS
    // The drain index never runs past the last buffered byte.
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drain_active_reg |-> (drain_idx_reg <= drain_last_reg))
        else $error("drain index beyond last buffered byte");

    // While buffered bytes drain, the screen phase has already been left.
    a_drain_phase: assert property (@(posedge clk) disable iff (!rst_n)
        drain_active_reg |-> (phase_reg != PH_SCREEN))
        else $error("drain active during screen phase");

    // A result that carries no text byte is always the closing marker of a window.
    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !byte_valid) |-> (window_end && (plain_byte == '0)))
        else $error("non-text result without window end");

    // Every text byte counts towards a non-zero length.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && byte_valid) |-> (text_length != '0))
        else $error("text byte with zero length");

    // Extension only runs once a full screen has been passed.
    a_extend_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXTEND) |-> (position_reg >= POS_W'(SCREEN_BYTES)))
        else $error("extension phase before a full screen");
`endif

endmodule

`default_nettype wire
